FILE: design/lzsd_pkg.sv
`default_nettype none

package lzsd_pkg;

  // history window geometry
  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam logic [WIN_AW-1:0] WRITE_POS_RESET = 12'hfee;

  // match length coding: low nibble plus bias, 3 to 18
  localparam int unsigned LEN_W      = 5;
  localparam logic [LEN_W-1:0] MATCH_BIAS = 5'd3;

  // flag register: remaining flag bits below a marker one
  localparam int unsigned FLAG_W = 9;
  localparam logic [FLAG_W-1:0] FLAG_MARKER = 9'h100;

  // configuration register indexes (paddr[2])
  localparam logic REG_IDX_INVERT  = 1'b0;
  localparam logic REG_IDX_OUT_LEN = 1'b1;

  // command from the parser to the copy engine
  typedef struct packed {
    logic              is_lit;
    logic [7:0]        lit;
    logic [WIN_AW-1:0] offset;
    logic [LEN_W-1:0]  count;
    logic              done;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/lzsd_ram.sv
`default_nettype none

module lzsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/lzsd_cmd_fifo.sv
`default_nettype none

module lzsd_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lzsd_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output lzsd_pkg::cmd_t     pop_cmd_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  lzsd_pkg::cmd_t  slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("command popped from empty queue");

endmodule

`default_nettype wire

FILE: design/lzsd_front.sv
`default_nettype none

module lzsd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          invert_i,
  input  wire logic [31:0]   out_len_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  output logic               push_o,
  output lzsd_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_FLAG_LOADED,
    PH_MATCH_HI
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [lzsd_pkg::FLAG_W-1:0]   flag_q, flag_d;
  logic [7:0]                    off_lo_q, off_lo_d;
  logic [31:0]                   produced_q, produced_d;

  logic                          active;
  logic [31:0]                   remain;
  logic [7:0]                    b;
  logic [lzsd_pkg::LEN_W-1:0]    len;
  logic [lzsd_pkg::LEN_W-1:0]    cnt;
  logic [lzsd_pkg::FLAG_W-1:0]   flag_sh;

  assign active  = (produced_q < out_len_i);
  assign remain  = out_len_i - produced_q;
  assign b       = in_byte_i ^ {8{invert_i}};
  assign len     = {1'b0, b[3:0]} + lzsd_pkg::MATCH_BIAS;
  assign cnt     = (remain < 32'(len)) ? remain[lzsd_pkg::LEN_W-1:0] : len;
  assign flag_sh = {1'b0, flag_q[lzsd_pkg::FLAG_W-1:1]};

  always_comb begin
    phase_d    = phase_q;
    flag_d     = flag_q;
    off_lo_d   = off_lo_q;
    produced_d = produced_q;
    push_o     = 1'b0;
    cmd_o      = '0;
    if (accept_i && active) begin
      unique case (phase_q)
        PH_MATCH_HI: begin
          push_o       = 1'b1;
          cmd_o.is_lit = 1'b0;
          cmd_o.offset = {b[7:4], off_lo_q};
          cmd_o.count  = cnt;
          cmd_o.done   = (remain <= 32'(len));
          produced_d   = produced_q + 32'(cnt);
          phase_d      = PH_TOKEN;
        end
        PH_TOKEN, PH_FLAG_LOADED: begin
          logic [lzsd_pkg::FLAG_W-1:0] fb;
          fb = (phase_q == PH_TOKEN) ? flag_sh : flag_q;
          flag_d = fb;
          if ((phase_q == PH_TOKEN) && (fb <= 9'd1)) begin
            // new flag byte
            flag_d  = {1'b0, b} | lzsd_pkg::FLAG_MARKER;
            phase_d = PH_FLAG_LOADED;
          end else if (fb[0]) begin
            push_o       = 1'b1;
            cmd_o.is_lit = 1'b1;
            cmd_o.lit    = b;
            cmd_o.count  = lzsd_pkg::LEN_W'(1);
            cmd_o.done   = (remain == 32'd1);
            produced_d   = produced_q + 32'd1;
            phase_d      = PH_TOKEN;
          end else begin
            off_lo_d = b;
            phase_d  = PH_MATCH_HI;
          end
        end
        default: begin
          phase_d = PH_TOKEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TOKEN;
      flag_q     <= '0;
      off_lo_q   <= '0;
      produced_q <= '0;
    end else begin
      phase_q    <= phase_d;
      flag_q     <= flag_d;
      off_lo_q   <= off_lo_d;
      produced_q <= produced_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/lzsd_back.sv
`default_nettype none

module lzsd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  wire lzsd_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output logic [7:0]         m_data_o,
  output logic               m_last_o,
  output logic               m_done_o
);

  localparam int unsigned AW = lzsd_pkg::WIN_AW;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e                     state_q, state_d;
  logic [AW-1:0]              clr_addr_q, clr_addr_d;
  logic [AW-1:0]              wpos_q, wpos_d;
  logic [AW-1:0]              rd_addr_q, rd_addr_d;
  logic [lzsd_pkg::LEN_W-1:0] left_q, left_d;
  logic                       is_lit_q, is_lit_d;
  logic [7:0]                 lit_q, lit_d;
  logic                       done_q, done_d;
  logic                       m_valid_q, m_valid_d;
  logic [7:0]                 m_data_q, m_data_d;
  logic                       m_last_q, m_last_d;
  logic                       m_done_q, m_done_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [7:0]                 ram_wdata;
  logic                       ram_re;
  logic [7:0]                 ram_rdata;
  logic                       out_free;
  logic [7:0]                 emit_byte;
  logic                       last_byte;

  lzsd_ram #(
    .Width(8),
    .Depth(lzsd_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_addr_q),
    .rdata_o(ram_rdata)
  );

  assign out_free   = !m_valid_q || m_ready_i;
  assign emit_byte  = is_lit_q ? lit_q : ram_rdata;
  assign last_byte  = is_lit_q || (left_q == lzsd_pkg::LEN_W'(1));
  assign clearing_o = (state_q == ST_CLEAR);
  assign m_valid_o  = m_valid_q;
  assign m_data_o   = m_data_q;
  assign m_last_o   = m_last_q;
  assign m_done_o   = m_done_q;

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    wpos_d     = wpos_q;
    rd_addr_d  = rd_addr_q;
    left_d     = left_q;
    is_lit_d   = is_lit_q;
    lit_d      = lit_q;
    done_d     = done_q;
    m_valid_d  = m_valid_q && !m_ready_i;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    m_done_d   = m_done_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wpos_q;
    ram_wdata  = emit_byte;
    ram_re     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          is_lit_d  = cmd_i.is_lit;
          lit_d     = cmd_i.lit;
          done_d    = cmd_i.done;
          left_d    = cmd_i.count;
          rd_addr_d = cmd_i.offset;
          state_d   = cmd_i.is_lit ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        rd_addr_d = rd_addr_q + 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          // write back into the window, so overlapping copies repeat
          ram_we    = 1'b1;
          wpos_d    = wpos_q + 1'b1;
          m_valid_d = 1'b1;
          m_data_d  = emit_byte;
          m_last_d  = last_byte;
          m_done_d  = done_q;
          left_d    = left_q - 1'b1;
          state_d   = last_byte ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      wpos_q     <= lzsd_pkg::WRITE_POS_RESET;
      rd_addr_q  <= '0;
      left_q     <= '0;
      is_lit_q   <= 1'b0;
      lit_q      <= '0;
      done_q     <= 1'b0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_last_q   <= 1'b0;
      m_done_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      wpos_q     <= wpos_d;
      rd_addr_q  <= rd_addr_d;
      left_q     <= left_d;
      is_lit_q   <= is_lit_d;
      lit_q      <= lit_d;
      done_q     <= done_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
      m_last_q   <= m_last_d;
      m_done_q   <= m_done_d;
    end
  end

  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !pop_o) else $error("command taken during window clear");

  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_EMIT))
    else $error("window read not followed by emit");

endmodule

`default_nettype wire

FILE: design/lzsd_stream_top_placeholder.sv
`default_nettype none

`default_nettype wire

FILE: design/lzss_stream_decompressor.sv
`default_nettype none

// lzss decompressor with a 4096-byte history window. compressed bytes come in
// on the s_axis side, one per transaction; decompressed bytes leave on the
// m_axis side with tlast on the last byte caused by an input byte and tuser
// set on every byte of the input byte that reaches output_length. a parser
// takes each input byte as it is accepted and queues a literal or copy command; a
// copy engine carries the commands out against the window ram. a literal is
// emitted from its command; a match reads the window ram before each output byte,
// which is then emitted and written back into the window.
// flag bytes and the first byte of a match produce nothing.
// after reset the whole window is cleared, with s_axis_tready low.
// registers: 0x0 invert_input (bit 0), 0x4 output_length. once output_length
// bytes are out, further input bytes are taken and dropped.
module lzss_stream_decompressor #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // compressed input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // decompressed output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // run_last
  output logic [0:0]       m_axis_tuser,   // [0] stream_done
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic           invert_q, invert_d;
  logic [31:0]    out_len_q, out_len_d;
  logic           cfg_wr;

  logic           in_accept;
  logic           push;
  lzsd_pkg::cmd_t push_cmd;
  logic           full;
  logic           pop;
  lzsd_pkg::cmd_t pop_cmd;
  logic           empty;
  logic           clearing;
  logic           stream_done;

  // config port, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    invert_d  = invert_q;
    out_len_d = out_len_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        lzsd_pkg::REG_IDX_INVERT:  invert_d  = pwdata[0];
        lzsd_pkg::REG_IDX_OUT_LEN: out_len_d = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lzsd_pkg::REG_IDX_INVERT:  prdata = {31'b0, invert_q};
      lzsd_pkg::REG_IDX_OUT_LEN: prdata = out_len_q;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q  <= 1'b0;
      out_len_q <= '0;
    end else begin
      invert_q  <= invert_d;
      out_len_q <= out_len_d;
    end
  end

  // input held off while the queue is full or the window is being cleared
  assign s_axis_tready = !full && !clearing;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  lzsd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .invert_i (invert_q),
    .out_len_i(out_len_q),
    .accept_i (in_accept),
    .in_byte_i(s_axis_tdata),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  lzsd_cmd_fifo #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .pop_cmd_o (pop_cmd),
    .empty_o   (empty)
  );

  lzsd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .cmd_i     (pop_cmd),
    .pop_o     (pop),
    .clearing_o(clearing),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_done_o  (stream_done)
  );

  assign m_axis_tuser = stream_done;

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with work outstanding but no transaction on either side
  localparam int unsigned IDLE_LIMIT    = 20000;
  // covers a full-length match still in the copy engine plus the command queue
  localparam int unsigned SETTLE_CYCLES = 100;
  // receiver hold-off long enough to back the block up into its input
  localparam int unsigned LONG_HOLD     = 600;
  localparam int unsigned RAND_PHASES   = 7;
  localparam int unsigned PHASE_BYTES   = 58;

  // parser position in the compressed stream
  typedef enum logic [1:0] {
    PH_TOKEN     = 2'd0,  // next byte is a flag byte or a token's first byte
    PH_FLAG_HELD = 2'd1,  // flag byte loaded, next byte is a token's first byte
    PH_MATCH_HI  = 2'd2   // next byte is the second byte of a match
  } parse_e;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS = 2'd0,
    RX_COIN   = 2'd1,
    RX_SPARSE = 2'd2,
    RX_MOSTLY = 2'd3
  } stall_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } out_item_t;

  // decoder state mirror plus the queue of decompressed bytes still owed
  class decode_tracker;
    logic [7:0]                  window_q [lzsd_pkg::WINDOW_DEPTH];
    logic [lzsd_pkg::WIN_AW-1:0] wr_pos;
    logic [lzsd_pkg::FLAG_W-1:0] flags;
    parse_e                      phase;
    logic [7:0]                  off_lo;
    logic [31:0]                 produced;
    logic                        invert;
    logic [31:0]                 out_len;
    out_item_t                   batch[$];
    out_item_t                   expected_bytes[$];
    int unsigned                 n_errors;

    function new();
      foreach (window_q[i]) window_q[i] = 8'h00;
      wr_pos   = lzsd_pkg::WRITE_POS_RESET;
      flags    = '0;
      phase    = PH_TOKEN;
      off_lo   = '0;
      produced = '0;
      invert   = 1'b0;
      out_len  = '0;
      n_errors = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == lzsd_pkg::REG_IDX_INVERT) begin
        invert = value[0];
      end else begin
        out_len = value;
      end
    endfunction

    function void emit(logic [7:0] v);
      out_item_t item;
      window_q[wr_pos] = v;
      wr_pos           = wr_pos + 1'b1;
      item.data        = v;
      item.last        = 1'b0;
      item.done        = 1'b0;
      batch.push_back(item);
      produced++;
    endfunction

    // one compressed byte accepted: queue the bytes it decodes to
    function void take_byte(logic [7:0] raw);
      logic [7:0]                  b;
      logic [lzsd_pkg::WIN_AW-1:0] src;
      logic [lzsd_pkg::LEN_W-1:0]  len;
      int unsigned                 k;
      if (produced >= out_len) return;
      b = invert ? ~raw : raw;
      batch.delete();
      if (phase == PH_MATCH_HI) begin
        src = {b[7:4], off_lo};
        len = lzsd_pkg::LEN_W'(b[3:0]) + lzsd_pkg::MATCH_BIAS;
        // read after each write so overlapping copies repeat themselves
        for (k = 0; k < len && produced < out_len; k++) begin
          emit(window_q[src]);
          src = src + 1'b1;
        end
        phase = PH_TOKEN;
      end else begin
        if (phase != PH_FLAG_HELD) begin
          flags = flags >> 1;
          if (flags <= 1) begin
            flags = lzsd_pkg::FLAG_MARKER | lzsd_pkg::FLAG_W'(b);
            phase = PH_FLAG_HELD;
            return;
          end
        end
        if (flags[0]) begin
          emit(b);
          phase = PH_TOKEN;
        end else begin
          off_lo = b;
          phase  = PH_MATCH_HI;
        end
      end
      if (batch.size() != 0) begin
        batch[batch.size()-1].last = 1'b1;
        if (produced >= out_len) begin
          foreach (batch[i]) batch[i].done = 1'b1;
        end
        foreach (batch[i]) expected_bytes.push_back(batch[i]);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic done);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: output byte with none owed: data %02h last %0b done %0b",
                 $time, data, last, done);
        n_errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data || last !== want.last || done !== want.done) begin
        $display("%0t: expected data %02h last %0b done %0b, actual data %02h last %0b done %0b",
                 $time, want.data, want.last, want.done, data, last, done);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic [7:0] m_axis_tdata;        // [7:0] out_byte
  wire logic   m_axis_tlast;            // run_last
  wire logic [0:0] m_axis_tuser;        // [0] stream_done
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'd0;
  wire logic [31:0] prdata;
  wire logic   pready;

  decode_tracker tracker;
  logic [7:0]    tx_q[$];     // raw bytes waiting for the input side
  logic [7:0]    plain_q[$];  // decoded-domain bytes of the stream being built
  int unsigned   idle_cycles  = 0;
  logic          hold_req     = 1'b0;

  lzss_stream_decompressor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // input side: bursts of random length, random gaps, some bursts back to back
  int unsigned tx_burst = 0;
  int unsigned tx_gap   = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap != 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (tx_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tx_q.pop_front();
        if (tx_burst <= 1) begin
          tx_burst = $urandom_range(1, 24);
          tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          tx_burst--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: stall pattern switches at random, plus one
  // long hold-off on request while the input keeps offering bytes
  stall_e      rx_mode   = RX_ALWAYS;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = stall_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // transaction monitor: predict on input, compare on output, track progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.take_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else if (tx_q.size() != 0 || s_axis_tvalid || tracker.expected_bytes.size() != 0) begin
        idle_cycles++;
      end else begin
        idle_cycles = 0;
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("lzss_stream_decompressor: mismatch");
    $finish;
  end

  // apb write: setup cycle, then access until pready
  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, value);
  endtask

  // wait until every byte is taken and every owed output has come out,
  // then let the copy engine finish anything that owes nothing
  task automatic settle();
    do @(negedge clk_i);
    while (tx_q.size() != 0 || s_axis_tvalid || tracker.expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // encode the built stream with the current invert setting and run it
  task automatic play_stream();
    foreach (plain_q[i]) tx_q.push_back(tracker.invert ? ~plain_q[i] : plain_q[i]);
    plain_q.delete();
    settle();
  endtask

  // build a syntactically aligned stream from the parser's current state:
  // flag bytes where one is due, literals, and matches of which half hit
  // recent output (often overlapping it); a tenth of the bytes are noise
  task automatic gen_tokens(input int unsigned n_bytes);
    logic [lzsd_pkg::FLAG_W-1:0] g_flags;
    parse_e                      g_phase;
    logic [lzsd_pkg::WIN_AW-1:0] g_pos;
    logic [lzsd_pkg::WIN_AW-1:0] g_off;
    logic [7:0]                  v;
    logic [3:0]                  len_code;
    g_flags = tracker.flags;
    g_phase = tracker.phase;
    g_pos   = tracker.wr_pos;
    g_off   = {4'($urandom_range(0, 15)), tracker.off_lo};
    repeat (n_bytes) begin
      if (g_phase == PH_MATCH_HI) begin
        len_code = ($urandom_range(0, 3) == 0) ? 4'hf : 4'($urandom_range(0, 15));
        v        = {g_off[11:8], len_code};
        g_pos    = g_pos + len_code + lzsd_pkg::MATCH_BIAS;
        g_phase  = PH_TOKEN;
      end else begin
        if (g_phase == PH_TOKEN) begin
          g_flags = g_flags >> 1;
        end
        if (g_phase == PH_TOKEN && g_flags <= 1) begin
          case ($urandom_range(0, 7))
            0:       v = 8'h00;
            1:       v = 8'hff;
            default: v = 8'($urandom_range(0, 255));
          endcase
          g_flags = lzsd_pkg::FLAG_MARKER | lzsd_pkg::FLAG_W'(v);
          g_phase = PH_FLAG_HELD;
        end else if (g_flags[0]) begin
          v       = 8'($urandom_range(0, 255));
          g_pos   = g_pos + 1'b1;
          g_phase = PH_TOKEN;
        end else begin
          if ($urandom_range(0, 1) == 0) begin
            g_off = g_pos - lzsd_pkg::WIN_AW'($urandom_range(1, 40));
          end else begin
            g_off = lzsd_pkg::WIN_AW'($urandom_range(0, lzsd_pkg::WINDOW_DEPTH - 1));
          end
          v       = g_off[7:0];
          g_phase = PH_MATCH_HI;
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        v = 8'($urandom_range(0, 255));
      end
      plain_q.push_back(v);
    end
  endtask

  initial begin
    logic [31:0] len_val;
    tracker = new();
    rst_ni  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero output length: everything is dropped, state untouched
    reg_write(lzsd_pkg::REG_IDX_INVERT, 32'd0);
    reg_write(lzsd_pkg::REG_IDX_OUT_LEN, 32'd0);
    plain_q = '{8'hff, 8'h00};
    play_stream();

    // unlimited length: all-literal flag byte with edge values, then an
    // all-match flag byte: overlapping copy of full length, a copy that
    // wraps the window end, a copy of untouched zeros, a copy from the base
    reg_write(lzsd_pkg::REG_IDX_OUT_LEN, 32'hffff_ffff);
    plain_q = '{8'hff, 8'h00, 8'hff, 8'h5a, 8'ha5, 8'h01, 8'h80, 8'h7f, 8'hfe,
                8'h00, 8'hf5, 8'hff, 8'hff, 8'hf0, 8'h23, 8'h10, 8'h00, 8'h0f};
    play_stream();

    // inverted input, match cut short by the output length, then a byte
    // after completion that must be dropped
    reg_write(lzsd_pkg::REG_IDX_INVERT, 32'd1);
    reg_write(lzsd_pkg::REG_IDX_OUT_LEN, tracker.produced + 32'd5);
    plain_q = '{8'he0, 8'h3f, 8'h77};
    play_stream();

    // raised length resumes from the kept state, cut again
    reg_write(lzsd_pkg::REG_IDX_INVERT, 32'd0);
    reg_write(lzsd_pkg::REG_IDX_OUT_LEN, tracker.produced + 32'd3);
    plain_q = '{8'hf0, 8'hf2};
    play_stream();

    // random phases with random invert and length settings
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      reg_write(lzsd_pkg::REG_IDX_INVERT, 32'($urandom_range(0, 1)));
      if (p == 0) begin
        len_val = 32'hffff_ffff;
      end else begin
        case ($urandom_range(0, 3))
          0:       len_val = tracker.produced + 32'($urandom_range(5, 40));
          1:       len_val = 32'hffff_ffff;
          default: len_val = tracker.produced + 32'd5000;
        endcase
      end
      reg_write(lzsd_pkg::REG_IDX_OUT_LEN, len_val);
      gen_tokens(PHASE_BYTES);
      // first random phase runs into the long output hold-off
      if (p == 0) begin
        hold_req = 1'b1;
      end
      play_stream();
    end

    if (tracker.n_errors == 0 && tracker.expected_bytes.size() == 0) begin
      $display("lzss_stream_decompressor: match");
    end else begin
      $display("lzss_stream_decompressor: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
design/lzsd_pkg.sv
design/lzsd_ram.sv
design/lzsd_cmd_fifo.sv
design/lzsd_front.sv
design/lzsd_back.sv
design/lzsd_stream_top_placeholder.sv
design/lzss_stream_decompressor.sv
sim/tb.sv
